[rtl/float_to_custom_minifloat_convert_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the minifloat converter
// ----------------------------------------------------------------------------
`ifndef FLOAT_TO_CUSTOM_MINIFLOAT_CONVERT_DEFINES_SVH
`define FLOAT_TO_CUSTOM_MINIFLOAT_CONVERT_DEFINES_SVH
`ifndef SYNTH
`define FCM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define FCM_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FCM_ASSERT(label, clk, rst, prop, msg)
`define FCM_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[rtl/fcm_pkg.sv]
// ----------------------------------------------------------------------------
// fcm_pkg
// Shared types for the binary64 to custom float converter.
// ----------------------------------------------------------------------------
package fcm_pkg;
   localparam int unsigned SigWidth = 53;
   localparam int unsigned ShiftWidth = 7;

   localparam logic [1:0] CLS_ZERO = 2'd0;
   localparam logic [1:0] CLS_FIN  = 2'd1;
   localparam logic [1:0] CLS_INF  = 2'd2;
   localparam logic [1:0] CLS_NAN  = 2'd3;

   // classified item passed from front to back
   typedef struct packed {
      logic                  sign;
      logic [1:0]            cls;
      logic [SigWidth-1:0]   sig;
      logic signed [12:0]    etrue;
      logic signed [12:0]    shift;     // right shift amount s
      logic                  normal;
      logic [3:0]            w;
      logic [5:0]            f;
   } cls_item_type;
endpackage

[rtl/fcm_front.sv]
// ----------------------------------------------------------------------------
// fcm_front
// Accepts items, clamps the format, normalises and classifies each value.
// ----------------------------------------------------------------------------
module fcm_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [63:0]           in_bits,
   input  logic [3:0]            exp_w,
   input  logic [5:0]            frac_w,
   input  logic [10:0]           max_w,
   input  logic [5:0]            max_f,
   output logic                  out_valid,
   output fcm_pkg::cls_item_type out_item
);
   logic                  valid_ff;
   fcm_pkg::cls_item_type item_ff, item_in;

   logic [10:0]  se;
   logic [51:0]  sm;
   logic [52:0]  sig;
   logic [5:0]   tb;
   logic [3:0]   w;
   logic [5:0]   f;
   logic signed [12:0] lsb_exp, etrue, emin, q;

   always_comb begin
      se = in_bits[62:52];
      sm = in_bits[51:0];
      w = exp_w;
      if (w < 4'd2) w = 4'd2;
      if ({7'd0, w} > max_w) w = max_w[3:0];
      f = frac_w;
      if (f < 6'd1) f = 6'd1;
      if (f > max_f) f = max_f;
      sig = (se != 11'd0) ? {1'b1, sm} : {1'b0, sm};
      lsb_exp = (se != 11'd0) ? ($signed({2'b00, se}) - 13'sd1075) : -13'sd1074;
      tb = 6'd0;
      for (int i = 0; i < 53; i++) begin
         if (sig[i]) tb = 6'(i);
      end
      etrue = lsb_exp + $signed({7'd0, tb});
      emin = 13'sd2 - $signed(13'(1) <<< (w - 4'd1));
      q = ((etrue >= emin) ? etrue : emin) - $signed({7'd0, f});
      item_in.sign = in_bits[63];
      item_in.sig = sig;
      item_in.etrue = etrue;
      item_in.shift = q - lsb_exp;
      item_in.normal = (etrue >= emin);
      item_in.w = w;
      item_in.f = f;
      if (se == 11'h7FF) item_in.cls = (sm != 52'd0) ? fcm_pkg::CLS_NAN : fcm_pkg::CLS_INF;
      else if (se == 11'd0 && sm == 52'd0) item_in.cls = fcm_pkg::CLS_ZERO;
      else item_in.cls = fcm_pkg::CLS_FIN;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= in_valid;
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item = item_ff;
endmodule

[rtl/fcm_queue.sv]
// ----------------------------------------------------------------------------
// fcm_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module fcm_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_valid,
   input  fcm_pkg::cls_item_type wr_item,
   output logic                  rd_valid,
   output fcm_pkg::cls_item_type rd_item,
   input  logic                  rd_take
);
   `include "float_to_custom_minifloat_convert_defines.svh"
   fcm_pkg::cls_item_type slot_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wp_ff, rp_ff;

   always_comb begin
      count_in = count_ff + {1'b0, wr_valid} - {1'b0, rd_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (wr_valid) wp_ff <= ~wp_ff;
         if (rd_take) rp_ff <= ~rp_ff;
      end
      if (wr_valid) slot_ff[wp_ff] <= wr_item;
   end

   assign rd_valid = (count_ff != 2'd0);
   assign rd_item = slot_ff[rp_ff];

   `FCM_ASSERT(a_no_overfill, clock, reset, !(count_ff == 2'd2 && wr_valid && !rd_take),
      "queue overfilled")
   `FCM_ASSERT(a_no_underrun, clock, reset, !(rd_take && count_ff == 2'd0),
      "queue read while empty")
   `FCM_ASSERT(a_ptr_gap, clock, reset, (count_ff == 2'd1) == (wp_ff != rp_ff),
      "queue pointers disagree with count")
endmodule

[rtl/fcm_back.sv]
// ----------------------------------------------------------------------------
// fcm_back
// Rounds, handles carry and overflow, and registers the result.
// ----------------------------------------------------------------------------
module fcm_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  fcm_pkg::cls_item_type in_item,
   output logic                  out_valid,
   output logic                  out_sign,
   output logic [10:0]           out_exp,
   output logic [51:0]           out_frac,
   output logic                  out_ovf
);
   `include "float_to_custom_minifloat_convert_defines.svh"
   logic        valid_ff;
   logic        sign_ff, sign_in, ovf_ff, ovf_in;
   logic [10:0] exp_ff, exp_in;
   logic [51:0] frac_ff, frac_in;

   logic [63:0] kept, rem, half, hidden, all_ones, sig64;
   logic [5:0]  s;
   logic [6:0]  ls;
   logic signed [12:0] et, biased, bias;

   always_comb begin
      sig64 = {11'd0, in_item.sig};
      hidden = 64'd1 << in_item.f;
      all_ones = (64'd1 << in_item.w) - 64'd1;
      bias = $signed(13'(1) <<< (in_item.w - 4'd1)) - 13'sd1;
      et = in_item.etrue;
      kept = 64'd0;
      s = 6'd0;
      ls = 7'd0;
      rem = 64'd0;
      half = 64'd0;
      if (in_item.shift <= 13'sd0) begin
         ls = 7'(-in_item.shift);
         kept = sig64 << ls;
      end else if (in_item.shift >= 13'sd54) begin
         kept = 64'd0;
      end else begin
         s = in_item.shift[5:0];
         rem = sig64 & ((64'd1 << s) - 64'd1);
         half = 64'd1 << (s - 6'd1);
         kept = sig64 >> s;
         if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
      end
      sign_in = in_item.sign;
      exp_in = 11'd0;
      frac_in = 52'd0;
      ovf_in = 1'b0;
      biased = 13'sd0;
      unique case (in_item.cls)
         fcm_pkg::CLS_NAN: begin
            exp_in = all_ones[10:0];
            frac_in = 52'(64'd1 << (in_item.f - 6'd1));
         end
         fcm_pkg::CLS_INF: exp_in = all_ones[10:0];
         fcm_pkg::CLS_ZERO: ;
         default: begin
            if (in_item.normal) begin
               if (kept >= (hidden << 1)) begin
                  kept = kept >> 1;
                  et = et + 13'sd1;
               end
               biased = et + bias;
               if ({{51{biased[12]}}, biased} >= all_ones) begin
                  exp_in = all_ones[10:0];
                  ovf_in = 1'b1;
               end else begin
                  exp_in = biased[10:0];
                  frac_in = 52'(kept - hidden);
               end
            end else begin
               exp_in = (kept >= hidden) ? 11'd1 : 11'd0;
               frac_in = 52'(kept & (hidden - 64'd1));
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= in_valid;
      sign_ff <= sign_in;
      exp_ff <= exp_in;
      frac_ff <= frac_in;
      ovf_ff <= ovf_in;
   end

   assign out_valid = valid_ff;
   assign out_sign = sign_ff;
   assign out_exp = exp_ff;
   assign out_frac = frac_ff;
   assign out_ovf = ovf_ff;

   `FCM_ASSERT(a_ovf_sat, clock, reset, !(valid_ff && ovf_ff && frac_ff != 52'd0),
      "overflow result carries a fraction")
   `FCM_ASSERT(a_valid_follow, clock, reset, valid_ff == $past(in_valid),
      "result strobe lost or invented")
endmodule

[rtl/float_to_custom_minifloat_convert.sv]
// ----------------------------------------------------------------------------
// float_to_custom_minifloat_convert
// Converts binary64 values to a programmable IEEE-style format.
// ----------------------------------------------------------------------------
// Usage: drive req_value_bits with start high; an item is taken at each edge
// where start is high and busy is low. busy is held low, so an item may enter
// every cycle. Each result appears for one cycle with rsp_valid high, in
// order, after the front classifies and normalises it (leading-one search),
// the queue passes it on and the back rounds it.
// Throughput is one item per cycle, set by the front and back stages.
// The receiver cannot stall, so the queue never fills.
// The csr_ channel writes the exponent width (index 0) and the fraction width
// (index 1); csr_ready is always high. Write only while no item is in flight.
// Synchronous reset empties the pipeline and restores widths 8 and 23.
// ----------------------------------------------------------------------------
module float_to_custom_minifloat_convert #(
   parameter int MAX_EXP_WIDTH = 11,
   parameter int MAX_FRAC_WIDTH = 52
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_value_bits,
   output logic        rsp_valid,
   output logic        rsp_sign_bit,
   output logic [10:0] rsp_exponent_field,
   output logic [51:0] rsp_fraction_field,
   output logic        rsp_overflow_flag,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [63:0] csr_data
);
   localparam logic [0:0] REG_EXP_W = 1'b0;
   localparam logic [0:0] REG_FRAC_W = 1'b1;

   logic [3:0] exp_w_ff;
   logic [5:0] frac_w_ff;
   logic       f_valid, q_valid;
   fcm_pkg::cls_item_type f_item, q_item;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_w_ff <= 4'd8;
         frac_w_ff <= 6'd23;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_EXP_W: exp_w_ff <= csr_data[3:0];
            REG_FRAC_W: frac_w_ff <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   fcm_front u_front (
      .clock(clock), .reset(reset), .in_valid(start & ~busy), .in_bits(req_value_bits),
      .exp_w(exp_w_ff), .frac_w(frac_w_ff),
      .max_w(11'(MAX_EXP_WIDTH)), .max_f(6'(MAX_FRAC_WIDTH)),
      .out_valid(f_valid), .out_item(f_item)
   );

   fcm_queue u_queue (
      .clock(clock), .reset(reset), .wr_valid(f_valid), .wr_item(f_item),
      .rd_valid(q_valid), .rd_item(q_item), .rd_take(q_valid)
   );

   fcm_back u_back (
      .clock(clock), .reset(reset), .in_valid(q_valid), .in_item(q_item),
      .out_valid(rsp_valid), .out_sign(rsp_sign_bit), .out_exp(rsp_exponent_field),
      .out_frac(rsp_fraction_field), .out_ovf(rsp_overflow_flag)
   );
endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Minifloat converter testbench
// Drives binary64 patterns into the converter under a range of target
// formats and checks every result against a value from its row or a local
// round-to-nearest-even encoder. Directed rows come first, then a random
// mix that concentrates on tie, carry, subnormal and overflow boundaries.
// ----------------------------------------------------------------------------
module testbench;
   localparam logic REG_EXP_WIDTH  = 1'b0;
   localparam logic REG_FRAC_WIDTH = 1'b1;
   localparam int   DRAIN_CYCLES   = 6;

   typedef struct packed {
      logic        sign_bit;
      logic [10:0] exponent_field;
      logic [51:0] fraction_field;
      logic        overflow_flag;
   } mini_type;

   typedef struct {
      logic [63:0] value_bits;
      bit          typed;
      mini_type    known;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [63:0] req_value_bits = '0;
   logic        rsp_valid;
   logic        rsp_sign_bit;
   logic [10:0] rsp_exponent_field;
   logic [51:0] rsp_fraction_field;
   logic        rsp_overflow_flag;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = REG_EXP_WIDTH;
   logic [63:0] csr_data = '0;

   logic [3:0]  exp_width_reg;
   logic [5:0]  frac_width_reg;
   mini_type    pending_results[$];
   int          error_count = 0;
   int          idle_pct = 0;

   float_to_custom_minifloat_convert u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_value_bits(req_value_bits),
      .rsp_valid(rsp_valid), .rsp_sign_bit(rsp_sign_bit),
      .rsp_exponent_field(rsp_exponent_field),
      .rsp_fraction_field(rsp_fraction_field),
      .rsp_overflow_flag(rsp_overflow_flag),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("testbench: FAIL");
      $finish;
   end

   function automatic int msb_pos(logic [63:0] v);
      int p;
      p = 0;
      for (int i = 0; i < 64; i++)
         if (v[i]) p = i;
      return p;
   endfunction

   function automatic mini_type encode_minifloat(logic [63:0] v);
      mini_type    r;
      int          se, w, f, bias, emin, etrue, lsb_exp, q, s;
      logic [63:0] sm, sig, kept, rem, half, all_ones, hidden;
      r = '0;
      r.sign_bit = v[63];
      se = int'(v[62:52]);
      sm = {12'd0, v[51:0]};
      w = int'(exp_width_reg);
      f = int'(frac_width_reg);
      if (w < 2) w = 2;
      if (w > 11) w = 11;
      if (f < 1) f = 1;
      if (f > 52) f = 52;
      bias = (1 << (w - 1)) - 1;
      emin = 1 - bias;
      all_ones = (64'd1 << w) - 1;
      hidden = 64'd1 << f;
      if (se == 'h7FF) begin
         r.exponent_field = all_ones[10:0];
         r.fraction_field = (sm != 0) ? (52'd1 << (f - 1)) : '0;
      end else if (se != 0 || sm != 0) begin
         if (se != 0) begin
            sig = sm | (64'd1 << 52);
            lsb_exp = se - 1075;
         end else begin
            sig = sm;
            lsb_exp = -1074;
         end
         etrue = lsb_exp + msb_pos(sig);
         q = ((etrue >= emin) ? etrue : emin) - f;
         s = q - lsb_exp;
         if (s <= 0) kept = sig << (-s);
         else if (s >= 54) kept = 0;
         else begin
            rem = sig & ((64'd1 << s) - 1);
            half = 64'd1 << (s - 1);
            kept = sig >> s;
            if (rem > half || (rem == half && kept[0])) kept++;
         end
         if (etrue >= emin) begin
            if (kept >= (hidden << 1)) begin
               kept >>= 1;
               etrue++;
            end
            if (64'(etrue + bias) >= all_ones) begin
               r.exponent_field = all_ones[10:0];
               r.overflow_flag = 1'b1;
            end else begin
               r.exponent_field = 11'(etrue + bias);
               r.fraction_field = 52'(kept - hidden);
            end
         end else begin
            r.exponent_field = (kept >= hidden) ? 11'd1 : 11'd0;
            r.fraction_field = 52'(kept & (hidden - 1));
         end
      end
      return r;
   endfunction

   // random pattern biased towards the edges of the current target format
   function automatic logic [63:0] pick_value();
      int          w, f, bias, se, pos;
      logic [51:0] sm;
      w = (exp_width_reg < 2) ? 2 : (exp_width_reg > 11) ? 11 : int'(exp_width_reg);
      f = (frac_width_reg < 1) ? 1 : (frac_width_reg > 52) ? 52 : int'(frac_width_reg);
      bias = (1 << (w - 1)) - 1;
      sm = 52'({$urandom, $urandom});
      case ($urandom_range(9))
         0: return {$urandom, $urandom};
         1: begin
            case ($urandom_range(3))
               0: return {1'($urandom_range(1)), 63'd0};
               1: return {1'($urandom_range(1)), 11'h7FF, 52'd0};
               2: return {1'($urandom_range(1)), 11'h7FF, sm | 52'd1};
               default: return {1'($urandom_range(1)), 11'd0, sm};
            endcase
         end
         default: begin
            se = 1023 + $urandom_range(bias + f + 4) - (bias + f + 2);
            if ($urandom_range(1)) se = 1023 + bias - 1 + $urandom_range(3);
            if (se < 1) se = 1;
            if (se > 2046) se = 2046;
            pos = 52 - f;
            case ($urandom_range(3))
               0: if (pos > 0) sm = (sm >> pos << pos) | (52'd1 << (pos - 1));
               1: sm = '1;
               2: sm = sm >> $urandom_range(51);
               default: ;
            endcase
            return {1'($urandom_range(1)), 11'(se), sm};
         end
      endcase
   endfunction

   task automatic send_item(logic [63:0] v, bit typed, mini_type known);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_value_bits = v;
      do @(posedge clock); while (busy);
      pending_results.push_back(typed ? known : encode_minifloat(v));
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic wait_drained();
      start = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [63:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_EXP_WIDTH) exp_width_reg = data[3:0];
      else frac_width_reg = data[5:0];
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   always @(posedge clock) begin
      mini_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("result with no item outstanding");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_sign_bit !== want.sign_bit) begin
               $error("sign_bit exp %0h got %0h", want.sign_bit, rsp_sign_bit);
               error_count++;
            end
            if (rsp_exponent_field !== want.exponent_field) begin
               $error("exponent_field exp %0h got %0h", want.exponent_field,
                      rsp_exponent_field);
               error_count++;
            end
            if (rsp_fraction_field !== want.fraction_field) begin
               $error("fraction_field exp %0h got %0h", want.fraction_field,
                      rsp_fraction_field);
               error_count++;
            end
            if (rsp_overflow_flag !== want.overflow_flag) begin
               $error("overflow_flag exp %0h got %0h", want.overflow_flag,
                      rsp_overflow_flag);
               error_count++;
            end
         end
      end
   end

   initial begin
      stim_row_type rows[$];
      int           widths[8][2];
      int           guard;
      exp_width_reg = 4'd8;
      frac_width_reg = 6'd23;
      // binary32-shaped target after reset
      rows = '{
         '{64'h0000000000000000, 1, '{1'b0, 11'd0, 52'd0, 1'b0}},
         '{64'h8000000000000000, 1, '{1'b1, 11'd0, 52'd0, 1'b0}},
         '{64'h7FF0000000000000, 1, '{1'b0, 11'd255, 52'd0, 1'b0}},
         '{64'hFFF0000000000000, 1, '{1'b1, 11'd255, 52'd0, 1'b0}},
         '{64'h7FF8000000000000, 1, '{1'b0, 11'd255, 52'h400000, 1'b0}},
         '{64'hFFF0000000000001, 1, '{1'b1, 11'd255, 52'h400000, 1'b0}},
         '{64'hFFFFFFFFFFFFFFFF, 1, '{1'b1, 11'd255, 52'h400000, 1'b0}},
         '{64'h7FEFFFFFFFFFFFFF, 1, '{1'b0, 11'd255, 52'd0, 1'b1}},
         '{64'h3FF0000000000000, 1, '{1'b0, 11'd127, 52'd0, 1'b0}},
         '{64'h0000000000000001, 0, '0},
         '{64'h000FFFFFFFFFFFFF, 0, '0},
         '{64'h3FFFFFFFFFFFFFFF, 0, '0},
         '{64'h3FF0000010000000, 0, '0},
         '{64'h3FF0000030000000, 0, '0},
         '{64'h3FF0000010000001, 0, '0},
         '{64'h47EFFFFFE0000000, 0, '0},
         '{64'hC7EFFFFFDFFFFFFF, 0, '0},
         '{64'h36A0000000000000, 0, '0},
         '{64'h3690000000000000, 0, '0},
         '{64'h3690000000000001, 0, '0},
         '{64'h380FFFFFFFFFFFFF, 0, '0},
         '{64'h380FFFFFF0000000, 0, '0}
      };
      // extremes, clamped settings, a few ordinary ones and a random pair
      widths = '{'{11, 52}, '{2, 1}, '{0, 0}, '{15, 63}, '{5, 10}, '{11, 1}, '{2, 52},
                 '{-1, -1}};
      repeat (3) @(negedge clock);
      reset = 1'b0;
      foreach (rows[i]) send_item(rows[i].value_bits, rows[i].typed, rows[i].known);
      for (int ph = 0; ph < 9; ph++) begin
         // hold until the pipeline has emptied before touching the widths
         wait_drained();
         if (ph > 0) begin
            if (widths[ph-1][0] < 0) begin
               write_csr(REG_EXP_WIDTH, {$urandom, $urandom});
               write_csr(REG_FRAC_WIDTH, {$urandom, $urandom});
            end else begin
               write_csr(REG_EXP_WIDTH, {$urandom, 28'd0, 4'(widths[ph-1][0])});
               write_csr(REG_FRAC_WIDTH, {$urandom, 26'd0, 6'(widths[ph-1][1])});
            end
         end
         case (ph % 3)
            0: idle_pct = 0;
            1: idle_pct = 76;
            default: idle_pct = 24;
         endcase
         repeat (210) send_item(pick_value(), 0, '0);
      end
      start = 1'b0;
      guard = 0;
      while (pending_results.size() != 0 && guard < 1000) begin
         @(negedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         if (pending_results.size() != 0) $error("results still outstanding at end");
         $display("testbench: FAIL");
      end
      $finish;
   end
endmodule

[files.f]
+incdir+rtl
rtl/fcm_pkg.sv
rtl/fcm_front.sv
rtl/fcm_queue.sv
rtl/fcm_back.sv
rtl/float_to_custom_minifloat_convert.sv
dv/testbench.sv
